@@ hdl/wall_follow_dead_reckoning_mapper_assert.svh @@
// Assertion macros shared by the mapper's RTL files.
// Each macro samples on clk and is disabled while rst is high.
`ifndef WALL_FOLLOW_DEAD_RECKONING_MAPPER_ASSERT_SVH
`define WALL_FOLLOW_DEAD_RECKONING_MAPPER_ASSERT_SVH

// Same-cycle implication.
`define WFDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WFDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/wfdr_pkg.sv @@
// Shared types, constants and helper functions of the wall-follow mapper.
// No dependencies; used by every module of the block.
`default_nettype none

package wfdr_pkg;

  localparam int GRID_DIM_DEFAULT = 128;

  localparam int THR_W   = 12;
  localparam int HEAD_W  = 13;
  localparam int TICK_W  = 8;
  localparam int COORD_W = 7;

  localparam logic [HEAD_W-1:0] HEAD_WRAP   = 13'd8000;
  localparam logic [HEAD_W-1:0] OCTANT_SPAN = 13'd1000;

  localparam logic [THR_W-1:0]   NEAR_RST  = 12'd16;
  localparam logic [THR_W-1:0]   FAR_RST   = 12'd8;
  localparam logic [HEAD_W-1:0]  TURN_RST  = 13'd36;
  localparam logic [TICK_W-1:0]  MARK_RST  = 8'd3;
  localparam logic [THR_W-1:0]   STOP_RST  = 12'd600;
  localparam logic [COORD_W-1:0] START_X_RST = 7'd85;
  localparam logic [COORD_W-1:0] START_Y_RST = 7'd55;

  typedef enum logic [1:0] {
    STEER_LEFT     = 2'd0,
    STEER_STRAIGHT = 2'd1,
    STEER_RIGHT    = 2'd2
  } steer_t;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_INC  = 2'd1,
    DIR_DEC  = 2'd2
  } dir_t;

  typedef struct packed {
    dir_t col_dir;
    dir_t row_dir;
  } step_t;

  // Classified item as it travels from front to back.
  typedef struct packed {
    logic               is_read;
    steer_t             steer;
    logic               stop_hit;
    logic               rd_in_range;
    logic [COORD_W-1:0] rd_col;
    logic [COORD_W-1:0] rd_row;
  } item_t;

  // Position reload caused by a start_x or start_y write.
  typedef struct packed {
    logic               col_we;
    logic               row_we;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } pos_load_t;

  // Octant 0..7 of a heading in 0..7999.
  function automatic logic [2:0] octant_of(input logic [HEAD_W-1:0] h);
    logic [2:0] oct;
    oct = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (h >= HEAD_W'(k * int'(OCTANT_SPAN))) oct = 3'(k);
    end
    return oct;
  endfunction

  // Column and row direction of one step, clockwise from north.
  function automatic step_t step_of(input logic [2:0] oct);
    step_t s;
    unique case (oct)
      3'd0: s = '{col_dir: DIR_HOLD, row_dir: DIR_DEC};
      3'd1: s = '{col_dir: DIR_INC,  row_dir: DIR_DEC};
      3'd2: s = '{col_dir: DIR_INC,  row_dir: DIR_HOLD};
      3'd3: s = '{col_dir: DIR_INC,  row_dir: DIR_INC};
      3'd4: s = '{col_dir: DIR_HOLD, row_dir: DIR_INC};
      3'd5: s = '{col_dir: DIR_DEC,  row_dir: DIR_INC};
      3'd6: s = '{col_dir: DIR_DEC,  row_dir: DIR_HOLD};
      3'd7: s = '{col_dir: DIR_DEC,  row_dir: DIR_DEC};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hdl/wfdr_front.sv @@
// Front end: accepts input items and classifies them for the back end.
// Depends on wfdr_pkg.
`default_nettype none

module wfdr_front #(
  parameter int GRID_DIM = wfdr_pkg::GRID_DIM_DEFAULT
) (
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          opcode,
  input  wire logic [wfdr_pkg::THR_W-1:0]    side_distance,
  input  wire logic [wfdr_pkg::THR_W-1:0]    stop_reading,
  input  wire logic [wfdr_pkg::COORD_W-1:0]  read_col,
  input  wire logic [wfdr_pkg::COORD_W-1:0]  read_row,
  input  wire logic [wfdr_pkg::THR_W-1:0]    near_threshold,
  input  wire logic [wfdr_pkg::THR_W-1:0]    far_threshold,
  input  wire logic [wfdr_pkg::THR_W-1:0]    stop_threshold,
  input  wire logic                          clear_busy,
  input  wire logic                          q_full,
  output logic                               push,
  output wfdr_pkg::item_t                    push_item
);

  assign in_ready = !q_full && !clear_busy;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.is_read  = opcode;
    push_item.stop_hit = (stop_reading >= stop_threshold);
    // left wins when the thresholds cross
    priority if (side_distance > near_threshold) begin
      push_item.steer = wfdr_pkg::STEER_LEFT;
    end else if (side_distance > far_threshold) begin
      push_item.steer = wfdr_pkg::STEER_STRAIGHT;
    end else begin
      push_item.steer = wfdr_pkg::STEER_RIGHT;
    end
    push_item.rd_in_range = (int'(read_col) < GRID_DIM) && (int'(read_row) < GRID_DIM);
    push_item.rd_col      = read_col;
    push_item.rd_row      = read_row;
  end

endmodule

`default_nettype wire

@@ hdl/wfdr_queue.sv @@
// Two-entry queue of classified items between front and back end.
// Depends on wfdr_pkg.
`default_nettype none

module wfdr_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire wfdr_pkg::item_t  push_item,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output wfdr_pkg::item_t       head_item
);

  wfdr_pkg::item_t entry [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      priority if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

@@ hdl/wfdr_back.sv @@
// Back end: heading, position, tick counter, stop flag, visit bitmap and result register.
// Depends on wfdr_pkg and the assertion macro header.
`default_nettype none

`include "wall_follow_dead_reckoning_mapper_assert.svh"

module wfdr_back #(
  parameter int GRID_DIM = wfdr_pkg::GRID_DIM_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          head_valid,
  input  wire wfdr_pkg::item_t               head_item,
  output logic                               pop,
  input  wire logic [wfdr_pkg::HEAD_W-1:0]   turn_step,
  input  wire logic [wfdr_pkg::TICK_W-1:0]   mark_interval,
  input  wire wfdr_pkg::pos_load_t           pos_load,
  output logic                               clear_busy,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         steer_cmd,
  output logic [wfdr_pkg::HEAD_W-1:0]        heading,
  output logic [wfdr_pkg::COORD_W-1:0]       pos_col,
  output logic [wfdr_pkg::COORD_W-1:0]       pos_row,
  output logic                               moved,
  output logic                               clamped,
  output logic                               stopped,
  output logic                               cell_value
);

  localparam int PW = $clog2(GRID_DIM);
  localparam int AW = 2 * PW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam logic [PW-1:0] POS_LAST = PW'(GRID_DIM - 1);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  function automatic logic [PW-1:0] fit_grid(input logic [wfdr_pkg::COORD_W-1:0] v);
    return (int'(v) >= GRID_DIM) ? POS_LAST : PW'(v);
  endfunction

  state_t                      state;
  state_t                      state_next;
  logic [AW-1:0]               clr_addr;
  logic                        visit_mem [MEM_DEPTH];

  logic [wfdr_pkg::HEAD_W-1:0] heading_r;
  logic [PW-1:0]               col_r;
  logic [PW-1:0]               row_r;
  logic [wfdr_pkg::TICK_W-1:0] tick_r;
  logic                        done_r;

  logic [wfdr_pkg::HEAD_W-1:0] heading_next;
  logic [PW-1:0]               col_next;
  logic [PW-1:0]               row_next;
  logic [wfdr_pkg::TICK_W-1:0] tick_next;
  logic                        done_next;
  logic                        mark;
  logic                        held;
  wfdr_pkg::steer_t            steer_res;

  logic [wfdr_pkg::HEAD_W-1:0] ts;
  logic [wfdr_pkg::HEAD_W:0]   turn_sum;
  logic                        is_tick;
  wfdr_pkg::step_t             step;
  logic                        adv;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rd_addr;

  // result register
  logic                        b_valid;
  wfdr_pkg::steer_t            b_steer;
  logic [wfdr_pkg::HEAD_W-1:0] b_heading;
  logic [wfdr_pkg::COORD_W-1:0] b_col;
  logic [wfdr_pkg::COORD_W-1:0] b_row;
  logic                        b_moved;
  logic                        b_clamped;
  logic                        b_stopped;
  logic                        b_read_ok;
  logic                        rd_bit;

  assign clear_busy = (state == ST_CLEAR);
  assign adv        = (state == ST_RUN) && head_valid && (!b_valid || out_ready);
  assign pop        = adv;
  assign is_tick    = !head_item.is_read && !done_r;

  always_comb begin
    ts = (turn_step >= wfdr_pkg::HEAD_WRAP) ? turn_step - wfdr_pkg::HEAD_WRAP : turn_step;
    turn_sum     = {1'b0, heading_r} + {1'b0, ts};
    heading_next = heading_r;
    steer_res    = wfdr_pkg::STEER_STRAIGHT;
    if (is_tick) begin
      steer_res = head_item.steer;
      unique case (head_item.steer)
        wfdr_pkg::STEER_LEFT: begin
          heading_next = (heading_r >= ts) ? heading_r - ts :
                         wfdr_pkg::HEAD_W'({1'b0, heading_r} +
                         {1'b0, wfdr_pkg::HEAD_WRAP} - {1'b0, ts});
        end
        wfdr_pkg::STEER_RIGHT: begin
          heading_next = (turn_sum >= {1'b0, wfdr_pkg::HEAD_WRAP}) ?
                         wfdr_pkg::HEAD_W'(turn_sum - {1'b0, wfdr_pkg::HEAD_WRAP}) :
                         turn_sum[wfdr_pkg::HEAD_W-1:0];
        end
        default: heading_next = heading_r;
      endcase
    end

    step      = wfdr_pkg::step_of(wfdr_pkg::octant_of(heading_next));
    mark      = is_tick && (tick_r == mark_interval);
    held      = 1'b0;
    col_next  = col_r;
    row_next  = row_r;
    tick_next = tick_r;
    if (is_tick) begin
      tick_next = tick_r + 1'b1;
    end
    if (mark) begin
      tick_next = wfdr_pkg::TICK_W'(1);
      case (step.col_dir)
        wfdr_pkg::DIR_INC: begin
          if (col_r >= POS_LAST) held = 1'b1;
          else col_next = col_r + 1'b1;
        end
        wfdr_pkg::DIR_DEC: begin
          if (col_r == '0) held = 1'b1;
          else col_next = col_r - 1'b1;
        end
        default: col_next = col_r;
      endcase
      case (step.row_dir)
        wfdr_pkg::DIR_INC: begin
          if (row_r >= POS_LAST) held = 1'b1;
          else row_next = row_r + 1'b1;
        end
        wfdr_pkg::DIR_DEC: begin
          if (row_r == '0) held = 1'b1;
          else row_next = row_r - 1'b1;
        end
        default: row_next = row_r;
      endcase
    end
    done_next = done_r || (is_tick && head_item.stop_hit);
    wr_addr   = {row_next, col_next};
    rd_addr   = {PW'(head_item.rd_row), PW'(head_item.rd_col)};
  end

  always_comb begin
    unique case (state)
      ST_CLEAR: state_next = (&clr_addr) ? ST_RUN : ST_CLEAR;
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_r <= '0;
      col_r     <= fit_grid(wfdr_pkg::START_X_RST);
      row_r     <= fit_grid(wfdr_pkg::START_Y_RST);
      tick_r    <= '0;
      done_r    <= 1'b0;
    end else begin
      if (adv) begin
        heading_r <= heading_next;
        tick_r    <= tick_next;
        done_r    <= done_next;
      end
      // a start write moves the position there
      if (pos_load.col_we) col_r <= fit_grid(pos_load.col);
      else if (adv) col_r <= col_next;
      if (pos_load.row_we) row_r <= fit_grid(pos_load.row);
      else if (adv) row_r <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      visit_mem[clr_addr] <= 1'b0;
    end else if (adv && mark) begin
      visit_mem[wr_addr] <= 1'b1;
    end
    if (adv) rd_bit <= visit_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= 1'b1;
    end else if (out_ready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_steer   <= steer_res;
      b_heading <= heading_next;
      b_col     <= wfdr_pkg::COORD_W'(col_next);
      b_row     <= wfdr_pkg::COORD_W'(row_next);
      b_moved   <= mark;
      b_clamped <= held;
      b_stopped <= done_next;
      b_read_ok <= head_item.is_read && head_item.rd_in_range;
    end
  end

  assign out_valid  = b_valid;
  assign steer_cmd  = b_steer;
  assign heading    = b_heading;
  assign pos_col    = b_col;
  assign pos_row    = b_row;
  assign moved      = b_moved;
  assign clamped    = b_clamped;
  assign stopped    = b_stopped;
  assign cell_value = rd_bit & b_read_ok;

  `WFDR_ASSERT_NOW(a_no_exec_in_clear, state == ST_CLEAR, !adv, "item executed during map clear")
  `WFDR_ASSERT_NOW(a_heading_range, 1'b1, heading_r < wfdr_pkg::HEAD_WRAP, "heading out of range")
  `WFDR_ASSERT_NOW(a_clamp_needs_move, b_valid && b_clamped, b_moved, "clamp without a step")
  `WFDR_ASSERT_NEXT(a_frozen_hold, adv && done_r && !pos_load.col_we && !pos_load.row_we, $stable(heading_r) && $stable(col_r) && $stable(row_r) && $stable(tick_r), "state moved after stop")

endmodule

`default_nettype wire

@@ hdl/wall_follow_dead_reckoning_mapper.sv @@
// Wall-follow dead-reckoning mapper: APB registers, front end, queue, back end.
// An accepted item passes the queue, then the result register, before its result can be taken.
// Throughput: one item per cycle while the receiver takes each result and no map clear runs.
// Reset (synchronous, rst high): registers take their defaults, then a clearing pass writes
// every bitmap entry, 2**(2*clog2(GRID_DIM)) of them (16384 at 128); no item is taken meanwhile.
// Depends on wfdr_pkg, wfdr_front, wfdr_queue, wfdr_back.
`default_nettype none

module wall_follow_dead_reckoning_mapper #(
  parameter int GRID_DIM = wfdr_pkg::GRID_DIM_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [4:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          opcode,
  input  wire logic [wfdr_pkg::THR_W-1:0]    side_distance,
  input  wire logic [wfdr_pkg::THR_W-1:0]    stop_reading,
  input  wire logic [wfdr_pkg::COORD_W-1:0]  read_col,
  input  wire logic [wfdr_pkg::COORD_W-1:0]  read_row,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         steer_cmd,
  output logic [wfdr_pkg::HEAD_W-1:0]        heading,
  output logic [wfdr_pkg::COORD_W-1:0]       pos_col,
  output logic [wfdr_pkg::COORD_W-1:0]       pos_row,
  output logic                               moved,
  output logic                               clamped,
  output logic                               stopped,
  output logic                               cell_value
);

  localparam logic [2:0] REG_NEAR    = 3'd0;
  localparam logic [2:0] REG_FAR     = 3'd1;
  localparam logic [2:0] REG_TURN    = 3'd2;
  localparam logic [2:0] REG_MARK    = 3'd3;
  localparam logic [2:0] REG_STOP    = 3'd4;
  localparam logic [2:0] REG_START_X = 3'd5;
  localparam logic [2:0] REG_START_Y = 3'd6;

  logic [wfdr_pkg::THR_W-1:0]   near_threshold;
  logic [wfdr_pkg::THR_W-1:0]   far_threshold;
  logic [wfdr_pkg::HEAD_W-1:0]  turn_step;
  logic [wfdr_pkg::TICK_W-1:0]  mark_interval;
  logic [wfdr_pkg::THR_W-1:0]   stop_threshold;
  logic [wfdr_pkg::COORD_W-1:0] start_x;
  logic [wfdr_pkg::COORD_W-1:0] start_y;

  logic                 wr_en;
  logic [2:0]           reg_idx;
  wfdr_pkg::pos_load_t  pos_load;
  logic                 clear_busy;
  logic                 q_full;
  logic                 push;
  wfdr_pkg::item_t      push_item;
  logic                 pop;
  logic                 head_valid;
  wfdr_pkg::item_t      head_item;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold <= wfdr_pkg::NEAR_RST;
      far_threshold  <= wfdr_pkg::FAR_RST;
      turn_step      <= wfdr_pkg::TURN_RST;
      mark_interval  <= wfdr_pkg::MARK_RST;
      stop_threshold <= wfdr_pkg::STOP_RST;
      start_x        <= wfdr_pkg::START_X_RST;
      start_y        <= wfdr_pkg::START_Y_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NEAR:    near_threshold <= pwdata[wfdr_pkg::THR_W-1:0];
        REG_FAR:     far_threshold  <= pwdata[wfdr_pkg::THR_W-1:0];
        REG_TURN:    turn_step      <= pwdata[wfdr_pkg::HEAD_W-1:0];
        REG_MARK:    mark_interval  <= pwdata[wfdr_pkg::TICK_W-1:0];
        REG_STOP:    stop_threshold <= pwdata[wfdr_pkg::THR_W-1:0];
        REG_START_X: start_x        <= pwdata[wfdr_pkg::COORD_W-1:0];
        REG_START_Y: start_y        <= pwdata[wfdr_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NEAR:    prdata = 32'(near_threshold);
      REG_FAR:     prdata = 32'(far_threshold);
      REG_TURN:    prdata = 32'(turn_step);
      REG_MARK:    prdata = 32'(mark_interval);
      REG_STOP:    prdata = 32'(stop_threshold);
      REG_START_X: prdata = 32'(start_x);
      REG_START_Y: prdata = 32'(start_y);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    pos_load.col_we = wr_en && (reg_idx == REG_START_X);
    pos_load.row_we = wr_en && (reg_idx == REG_START_Y);
    pos_load.col    = pwdata[wfdr_pkg::COORD_W-1:0];
    pos_load.row    = pwdata[wfdr_pkg::COORD_W-1:0];
  end

  wfdr_front #(
    .GRID_DIM (GRID_DIM)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .side_distance  (side_distance),
    .stop_reading   (stop_reading),
    .read_col       (read_col),
    .read_row       (read_row),
    .near_threshold (near_threshold),
    .far_threshold  (far_threshold),
    .stop_threshold (stop_threshold),
    .clear_busy     (clear_busy),
    .q_full         (q_full),
    .push           (push),
    .push_item      (push_item)
  );

  wfdr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  wfdr_back #(
    .GRID_DIM (GRID_DIM)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .turn_step     (turn_step),
    .mark_interval (mark_interval),
    .pos_load      (pos_load),
    .clear_busy    (clear_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .steer_cmd     (steer_cmd),
    .heading       (heading),
    .pos_col       (pos_col),
    .pos_row       (pos_row),
    .moved         (moved),
    .clamped       (clamped),
    .stopped       (stopped),
    .cell_value    (cell_value)
  );

endmodule

`default_nettype wire

@@ sim/wfdr_test_pkg.sv @@
// Register indexes and item codes shared by the mapper testbench files.
// No dependencies; compile before the checker and the testbench top.
package wfdr_test_pkg;

  typedef enum logic [2:0] {
    REG_NEAR    = 3'd0,
    REG_FAR     = 3'd1,
    REG_TURN    = 3'd2,
    REG_MARK    = 3'd3,
    REG_STOP    = 3'd4,
    REG_START_X = 3'd5,
    REG_START_Y = 3'd6
  } reg_index_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_READ = 1'b1
  } op_t;

endpackage

@@ sim/wfdr_map_checker.sv @@
// Checker for the wall-follow mapper: tracks register writes, predicts each item's report
// and compares it with the block's output. Depends on wfdr_pkg and wfdr_test_pkg.
module wfdr_map_checker
  import wfdr_pkg::*;
  import wfdr_test_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               opcode,
  input  logic [THR_W-1:0]   side_distance,
  input  logic [THR_W-1:0]   stop_reading,
  input  logic [COORD_W-1:0] read_col,
  input  logic [COORD_W-1:0] read_row,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         steer_cmd,
  input  logic [HEAD_W-1:0]  heading,
  input  logic [COORD_W-1:0] pos_col,
  input  logic [COORD_W-1:0] pos_row,
  input  logic               moved,
  input  logic               clamped,
  input  logic               stopped,
  input  logic               cell_value,
  output int                 fail_count,
  output int                 pending
);

  localparam int GRID = GRID_DIM_DEFAULT;

  typedef struct packed {
    steer_t             steer;
    logic [HEAD_W-1:0]  heading;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               moved;
    logic               clamped;
    logic               stopped;
    logic               cell_bit;
  } map_report_t;

  logic [THR_W-1:0]   near_thr, far_thr, stop_thr;
  logic [HEAD_W-1:0]  turn_step;
  logic [TICK_W-1:0]  mark_interval;
  logic [HEAD_W-1:0]  head;
  logic [COORD_W-1:0] col, row;
  logic [TICK_W-1:0]  tick_count;
  logic               frozen;
  bit                 visited [GRID*GRID];
  map_report_t        reports_due [$];
  int                 misses;

  function automatic logic [COORD_W-1:0] fit_grid(input logic [COORD_W-1:0] v);
    return (int'(v) >= GRID) ? COORD_W'(GRID - 1) : v;
  endfunction

  function automatic logic [COORD_W-1:0] step_axis(input logic [COORD_W-1:0] p, input int d,
                                                   inout bit held);
    if (d < 0) begin
      if (p == '0) begin
        held = 1'b1;
        return p;
      end
      return p - 1'b1;
    end
    if (d > 0) begin
      if (int'(p) + 1 >= GRID) begin
        held = 1'b1;
        return p;
      end
      return p + 1'b1;
    end
    return p;
  endfunction

  // Advance the mapper state by one item and return the report it produces.
  function automatic map_report_t predict_report(input op_t op, input logic [THR_W-1:0] side,
                                                 input logic [THR_W-1:0] stopr,
                                                 input logic [COORD_W-1:0] rc,
                                                 input logic [COORD_W-1:0] rr);
    map_report_t r;
    int ts, oct, dc, dr;
    bit held;
    r = '0;
    r.steer = STEER_STRAIGHT;
    if (op == OP_READ) begin
      if (int'(rc) < GRID && int'(rr) < GRID) r.cell_bit = visited[int'(rr) * GRID + int'(rc)];
    end else if (!frozen) begin
      ts = int'(turn_step);
      if (ts >= int'(HEAD_WRAP)) ts = ts - int'(HEAD_WRAP);
      if (side > near_thr) begin
        r.steer = STEER_LEFT;
        head = HEAD_W'((int'(head) + int'(HEAD_WRAP) - ts) % int'(HEAD_WRAP));
      end else if (side > far_thr) begin
        r.steer = STEER_STRAIGHT;
      end else begin
        r.steer = STEER_RIGHT;
        head = HEAD_W'((int'(head) + ts) % int'(HEAD_WRAP));
      end
      if (tick_count == mark_interval) begin
        oct = (int'(head) / int'(OCTANT_SPAN)) % 8;
        case (oct)
          0: begin dc = 0;  dr = -1; end
          1: begin dc = 1;  dr = -1; end
          2: begin dc = 1;  dr = 0;  end
          3: begin dc = 1;  dr = 1;  end
          4: begin dc = 0;  dr = 1;  end
          5: begin dc = -1; dr = 1;  end
          6: begin dc = -1; dr = 0;  end
          default: begin dc = -1; dr = -1; end
        endcase
        held = 1'b0;
        col = step_axis(col, dc, held);
        row = step_axis(row, dr, held);
        visited[int'(row) * GRID + int'(col)] = 1'b1;
        r.moved = 1'b1;
        r.clamped = held;
        tick_count = '0;
      end
      tick_count = tick_count + 1'b1;
      if (stopr >= stop_thr) frozen = 1'b1;
    end
    r.heading = head;
    r.col = col;
    r.row = row;
    r.stopped = frozen;
    return r;
  endfunction

  always @(posedge clk) begin : track_mapper
    map_report_t want, got;
    if (rst) begin
      near_thr = NEAR_RST;
      far_thr = FAR_RST;
      turn_step = TURN_RST;
      mark_interval = MARK_RST;
      stop_thr = STOP_RST;
      head = '0;
      col = fit_grid(START_X_RST);
      row = fit_grid(START_Y_RST);
      tick_count = '0;
      frozen = 1'b0;
      foreach (visited[i]) visited[i] = 1'b0;
      reports_due.delete();
      misses = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[4:2]))
          REG_NEAR:    near_thr = pwdata[THR_W-1:0];
          REG_FAR:     far_thr = pwdata[THR_W-1:0];
          REG_TURN:    turn_step = pwdata[HEAD_W-1:0];
          REG_MARK:    mark_interval = pwdata[TICK_W-1:0];
          REG_STOP:    stop_thr = pwdata[THR_W-1:0];
          REG_START_X: col = fit_grid(pwdata[COORD_W-1:0]);
          REG_START_Y: row = fit_grid(pwdata[COORD_W-1:0]);
          default: ;
        endcase
      end
      // Retire first: a result never belongs to an item taken at the same edge.
      if (out_valid && out_ready) begin
        got.steer = steer_t'(steer_cmd);
        got.heading = heading;
        got.col = pos_col;
        got.row = pos_row;
        got.moved = moved;
        got.clamped = clamped;
        got.stopped = stopped;
        got.cell_bit = cell_value;
        if (reports_due.size() == 0) begin
          misses++;
          if (misses <= 10) $display("mapper check: result with no item pending");
        end else begin
          want = reports_due.pop_front();
          if (got !== want) begin
            misses++;
            if (misses <= 10) begin
              $display("mapper check: expected steer %0d heading %0d pos %0d,%0d moved %b",
                       want.steer, want.heading, want.col, want.row, want.moved,
                       " clamped %b stopped %b cell %b",
                       want.clamped, want.stopped, want.cell_bit);
              $display("mapper check: actual   steer %0d heading %0d pos %0d,%0d moved %b",
                       steer_cmd, heading, pos_col, pos_row, moved,
                       " clamped %b stopped %b cell %b", clamped, stopped, cell_value);
            end
          end
        end
      end
      if (in_valid && in_ready)
        reports_due.push_back(predict_report(op_t'(opcode), side_distance, stop_reading,
                                             read_col, read_row));
    end
    fail_count <= misses;
    pending <= reports_due.size();
  end

endmodule

@@ sim/wall_follow_dead_reckoning_mapper_test.sv @@
// Testbench top for the wall-follow mapper: register setup, directed and random items,
// receiver stalls and the verdict. Depends on wfdr_pkg, wfdr_test_pkg and wfdr_map_checker.
module wall_follow_dead_reckoning_mapper_test;
  import wfdr_pkg::*;
  import wfdr_test_pkg::*;

  localparam int IDLE_LIMIT    = 50000;
  localparam int RANDOM_PHASES = 12;

  logic               clk;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               opcode = 1'b0;
  logic [THR_W-1:0]   side_distance = '0;
  logic [THR_W-1:0]   stop_reading = '0;
  logic [COORD_W-1:0] read_col = '0;
  logic [COORD_W-1:0] read_row = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         steer_cmd;
  logic [HEAD_W-1:0]  heading;
  logic [COORD_W-1:0] pos_col;
  logic [COORD_W-1:0] pos_row;
  logic               moved;
  logic               clamped;
  logic               stopped;
  logic               cell_value;
  int                 fail_count;
  int                 pending;

  // Register values as last written, used to aim side and stop readings.
  logic [THR_W-1:0]   near_set = NEAR_RST;
  logic [THR_W-1:0]   far_set = FAR_RST;
  logic [THR_W-1:0]   stop_set = STOP_RST;
  logic [COORD_W-1:0] seen_col = START_X_RST;
  logic [COORD_W-1:0] seen_row = START_Y_RST;
  int                 burst_left = 0;
  int                 idle_cycles = 0;
  int                 recv_left = 0;
  int                 recv_mode = 0;

  wall_follow_dead_reckoning_mapper i_dut (.*);
  wfdr_map_checker i_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: switch between always ready, random stalls, long stalls and toggling.
  always @(posedge clk) begin
    if (recv_left == 0) begin
      recv_mode <= $urandom_range(0, 3);
      recv_left <= $urandom_range(50, 200);
    end else begin
      recv_left <= recv_left - 1;
    end
    case (recv_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ((recv_left % 13) == 0);
      default: out_ready <= ~out_ready;
    endcase
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      seen_col <= pos_col;
      seen_row <= pos_row;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("wall_follow_dead_reckoning_mapper test failed");
      $finish;
    end
  end

  task automatic write_reg(input reg_index_t idx, input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_NEAR: near_set = THR_W'(value);
      REG_FAR:  far_set = THR_W'(value);
      REG_STOP: stop_set = THR_W'(value);
      default: ;
    endcase
  endtask

  task automatic send_item(input op_t op, input int unsigned side, input int unsigned stopr,
                           input int unsigned rc, input int unsigned rr);
    in_valid <= 1'b1;
    opcode <= op;
    side_distance <= THR_W'(side);
    stop_reading <= THR_W'(stopr);
    read_col <= COORD_W'(rc);
    read_row <= COORD_W'(rr);
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  // Wait until every report has come back, then let the pipeline empty.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic int unsigned pick_side();
    case ($urandom_range(0, 7))
      0: return near_set;
      1: return (near_set == '1) ? near_set : near_set + 1;
      2: return far_set;
      3: return (far_set == '1) ? far_set : far_set + 1;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  // Stay below the stop threshold so the run keeps moving.
  function automatic int unsigned pick_stop();
    return (stop_set == '0) ? 0 : $urandom_range(0, stop_set - 1);
  endfunction

  function automatic int unsigned jitter(input logic [COORD_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > 127) v = 127;
    return v;
  endfunction

  task automatic send_random_item();
    if ($urandom_range(0, 3) != 0)
      send_item(OP_TICK, pick_side(), pick_stop(), $urandom_range(0, 127),
                $urandom_range(0, 127));
    else if ($urandom_range(0, 4) < 3)
      send_item(OP_READ, $urandom_range(0, 4095), $urandom_range(0, 4095),
                jitter(seen_col), jitter(seen_row));
    else
      send_item(OP_READ, $urandom_range(0, 4095), $urandom_range(0, 4095),
                $urandom_range(0, 127), $urandom_range(0, 127));
  endtask

  task automatic configure_random();
    int unsigned v;
    if ($urandom_range(0, 3) != 0) write_reg(REG_FAR, $urandom_range(0, 3000));
    if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 5) == 0)
        v = $urandom_range(0, far_set);
      else
        v = int'(far_set) + $urandom_range(1, 1000);
      write_reg(REG_NEAR, (v > 4095) ? 4095 : v);
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 3))
        0: v = 0;
        1: v = $urandom_range(0, 300);
        2: v = $urandom_range(300, 2500);
        default: v = $urandom_range(0, 8191);
      endcase
      write_reg(REG_TURN, v);
    end
    if ($urandom_range(0, 3) != 0)
      write_reg(REG_MARK, ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6)
                                                      : $urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0)
      write_reg(REG_STOP, ($urandom_range(0, 3) != 0) ? $urandom_range(1500, 4095)
                                                      : $urandom_range(1, 4095));
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 3))
        0: v = 0;
        1: v = 127;
        default: v = $urandom_range(0, 127);
      endcase
      write_reg(REG_START_X, v);
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 3))
        0: v = 0;
        1: v = 127;
        default: v = $urandom_range(0, 127);
      endcase
      write_reg(REG_START_Y, v);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: map corners, each steering case at its boundaries, a first step.
    send_item(OP_READ, 0, 0, 0, 0);
    send_item(OP_READ, 4095, 4095, 127, 127);
    send_item(OP_TICK, 4095, 0, 0, 0);
    send_item(OP_TICK, 16, 599, 127, 127);
    send_item(OP_TICK, 17, 0, 0, 0);
    send_item(OP_TICK, 9, 0, 0, 0);
    send_item(OP_TICK, 8, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0);
    repeat (6) send_item(OP_TICK, 4095, 0, 0, 0);
    repeat (4) send_item(OP_TICK, 0, 0, 0, 0);
    // The start cell is never marked by reset.
    send_item(OP_READ, 0, 0, START_X_RST, START_Y_RST);
    drain();
    send_item(OP_READ, 0, 0, seen_col, seen_row);
    send_item(OP_READ, 0, 0, 127, 0);
    send_item(OP_READ, 0, 0, 0, 127);
    drain();

    // Corner start, every step clamps toward the edges, one-tick steps.
    write_reg(REG_NEAR, 4095);
    write_reg(REG_FAR, 0);
    write_reg(REG_TURN, 7999);
    write_reg(REG_MARK, 1);
    write_reg(REG_STOP, 4095);
    write_reg(REG_START_X, 0);
    write_reg(REG_START_Y, 0);
    repeat (120) send_random_item();
    drain();

    // Crossed thresholds, turn step past the wrap, counter-zero stepping.
    write_reg(REG_NEAR, 0);
    write_reg(REG_FAR, 4095);
    write_reg(REG_TURN, 8191);
    write_reg(REG_MARK, 0);
    write_reg(REG_STOP, 4094);
    write_reg(REG_START_X, 127);
    write_reg(REG_START_Y, 127);
    repeat (300) send_random_item();
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      configure_random();
      repeat (110) send_random_item();
      drain();
    end

    // Run until the stop reading hits its threshold exactly, then check the frozen state.
    configure_random();
    repeat (50) send_random_item();
    send_item(OP_TICK, pick_side(), stop_set, 0, 0);
    repeat (40) begin
      if ($urandom_range(0, 1) != 0)
        send_item(OP_TICK, $urandom_range(0, 4095), $urandom_range(0, 4095), 0, 0);
      else
        send_item(OP_READ, 0, 0, jitter(seen_col), jitter(seen_row));
    end
    drain();

    if (fail_count == 0 && pending == 0)
      $display("wall_follow_dead_reckoning_mapper test passed");
    else
      $display("wall_follow_dead_reckoning_mapper test failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/wfdr_pkg.sv
hdl/wfdr_front.sv
hdl/wfdr_queue.sv
hdl/wfdr_back.sv
hdl/wall_follow_dead_reckoning_mapper.sv
sim/wfdr_test_pkg.sv
sim/wfdr_map_checker.sv
sim/wall_follow_dead_reckoning_mapper_test.sv
